// ===== rtl/core/event_coalescing_cam_unit_macros.svh =====
// Assertion macros for the checker file of the coalescing store.
`ifndef EVENT_COALESCING_CAM_UNIT_MACROS_SVH
`define EVENT_COALESCING_CAM_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ECC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecc assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define ECC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecc assertion failed");

`endif

// ===== rtl/core/ecc_pkg.sv =====
// Shared types and constants of the event coalescing store.
package ecc_pkg;

    localparam int FLAG_W = 32;
    localparam int ID_W   = 16;
    localparam int KEY_W  = FLAG_W + ID_W;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [0:0]
    {
        ACT_CHECK = 1'b0,
        ACT_ADD   = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_DELIVER
    } state_t;

    typedef struct packed
    {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

// ===== rtl/core/ecc_key_ram.sv =====
// Key memory with per-entry valid bits; an entry never written reads as zero.
module ecc_key_ram #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ecc_pkg::ram_ctl_t           ctl,
    input  logic [AW-1:0]               wr_addr,
    input  ecc_pkg::key_t               wr_data,
    input  logic [AW-1:0]               rd_addr,
    output ecc_pkg::key_t               rd_data
);

    ecc_pkg::key_t      mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    ecc_pkg::key_t      rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/core/ecc_ctrl.sv =====
// Sequencer: walks the key memory for checks, writes the ring slot for adds.
module ecc_ctrl #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CW-1:0]       count,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [0:0]          in_action,
    input  ecc_pkg::key_t       in_key,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_found,
    output ecc_pkg::ram_ctl_t   ram_ctl,
    output logic [AW-1:0]       ram_wr_addr,
    output ecc_pkg::key_t       ram_wr_data,
    output logic [AW-1:0]       ram_rd_addr,
    input  ecc_pkg::key_t       ram_rd_data
);

    ecc_pkg::state_t    state_reg, state_next;
    ecc_pkg::key_t      key_reg, key_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic               res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic               found_reg;
    logic               load;
    logic [AW-1:0]      ins_slot;
    logic [CW-1:0]      slot_inc;
    logic [CW-1:0]      idx_inc;

    // A slot left beyond a lowered count restarts at entry zero.
    assign ins_slot = ({{(CW-AW){1'b0}}, slot_reg} >= count) ? '0 : slot_reg;
    assign slot_inc = {{(CW-AW){1'b0}}, ins_slot} + CW'(1);
    assign idx_inc  = {{(CW-AW){1'b0}}, idx_reg} + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecc_pkg::ST_IDLE;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (load)
        begin
            found_reg <= res_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        res_next    = res_reg;
        in_ready    = 1'b0;
        load        = 1'b0;
        ram_ctl     = '0;
        ram_wr_addr = ins_slot;
        ram_wr_data = in_key;
        ram_rd_addr = '0;

        case (state_reg)
            ecc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next = in_key;
                    res_next = 1'b0;
                    if (in_action == ecc_pkg::ACT_ADD)
                    begin
                        // Drop zero keys: zero marks an empty entry.
                        if (in_key != '0)
                        begin
                            ram_ctl.wr_en = 1'b1;
                            slot_next = (slot_inc >= count) ? '0 : AW'(slot_inc);
                        end
                        state_next = ecc_pkg::ST_DELIVER;
                    end
                    else if (in_key == '0)
                    begin
                        state_next = ecc_pkg::ST_DELIVER;
                    end
                    else
                    begin
                        ram_ctl.rd_en = 1'b1;
                        ram_rd_addr   = '0;
                        idx_next      = '0;
                        state_next    = ecc_pkg::ST_SEARCH;
                    end
                end
            end

            ecc_pkg::ST_SEARCH:
            begin
                if (ram_rd_data == '0)
                begin
                    res_next   = 1'b0;
                    state_next = ecc_pkg::ST_DELIVER;
                end
                else if (ram_rd_data == key_reg)
                begin
                    res_next   = 1'b1;
                    state_next = ecc_pkg::ST_DELIVER;
                end
                else if (idx_inc >= count)
                begin
                    res_next   = 1'b0;
                    state_next = ecc_pkg::ST_DELIVER;
                end
                else
                begin
                    // Advance to the next entry in use.
                    ram_ctl.rd_en = 1'b1;
                    ram_rd_addr   = AW'(idx_inc);
                    idx_next      = AW'(idx_inc);
                end
            end

            ecc_pkg::ST_DELIVER:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = ecc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ecc_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = found_reg;

endmodule

// ===== rtl/core/event_coalescing_cam_unit.sv =====
// Event coalescing store: top level with the count register and stream ports.
//
// Every accepted word yields exactly one result word. An add or a check of the
// zero key passes from IDLE to DELIVER: the key memory is written at the
// accepting edge and the output register loads once DELIVER finds it free. A
// check of a nonzero key passes from IDLE through SEARCH to DELIVER; SEARCH
// reads entries through the single read port of the key memory, one entry per
// cycle, until the search ends (the first empty entry, the first match or the
// end of the entries in use), so it reads at most entries_in_use entries.
// The next word is accepted in the cycle after the result loads into the output
// register, even while it waits there, so no new word is taken before the last
// one's result has loaded; a result held by a stalled sink stalls the next
// load. After reset the store reads empty at once: per-entry valid bits
// cleared by reset stand in for a clearing pass. entries_in_use is clamped to
// 1..DEPTH and must be written only while the block is idle.
module event_coalescing_cam_unit #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ecc_pkg::CFG_W-1:0]   cfg_wr_data,     // entries_in_use
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,    // flag_word[31:0], event_id[47:32]
    input  logic [0:0]                  s_axis_tuser,    // action[0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata     // found[0], zero fill[7:1]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = (CW > ecc_pkg::CFG_W) ? CW : ecc_pkg::CFG_W;

    logic [ecc_pkg::CFG_W-1:0]  cfg_reg;
    logic [NW-1:0]              cfg_ext;
    logic [NW-1:0]              count_wide;
    logic [CW-1:0]              count;
    ecc_pkg::key_t              in_key;
    ecc_pkg::ram_ctl_t          ram_ctl;
    logic [AW-1:0]              ram_wr_addr;
    logic [AW-1:0]              ram_rd_addr;
    ecc_pkg::key_t              ram_wr_data;
    ecc_pkg::key_t              ram_rd_data;
    logic                       found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ecc_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Clamp the count to 1..DEPTH.
    always_comb
    begin
        cfg_ext = NW'(cfg_reg);
        if (cfg_ext == '0)
        begin
            count_wide = NW'(1);
        end
        else if (cfg_ext > NW'(DEPTH))
        begin
            count_wide = NW'(DEPTH);
        end
        else
        begin
            count_wide = cfg_ext;
        end
    end

    assign count  = count_wide[CW-1:0];
    assign in_key = {s_axis_tdata[31:0], s_axis_tdata[47:32]};

    ecc_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .count       (count),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser),
        .in_key      (in_key),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_found   (found),
        .ram_ctl     (ram_ctl),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    ecc_key_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ram_ctl),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_axis_tdata = {7'b0, found};

endmodule

// ===== rtl/core/ecc_checker.sv =====
// Port-level checker of the coalescing store and its bind to the top level.
`include "event_coalescing_cam_unit_macros.svh"

module ecc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [7:0]   m_axis_tdata
);

    logic       in_acc;
    logic       out_acc;
    logic       out_wait;
    logic [1:0] pending_reg;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign out_wait = m_axis_tvalid && !m_axis_tready;

    // Count words accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    `ECC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    `ECC_ASSERT_NEXT(a_ready_drop, clk, rst_n, in_acc, !s_axis_tready)
    `ECC_ASSERT_SAME(a_no_spurious, clk, rst_n, m_axis_tvalid, pending_reg != 2'd0)
    `ECC_ASSERT_SAME(a_accept_limit, clk, rst_n, in_acc, pending_reg == 2'd0 || pending_reg == 2'd1)

endmodule

bind event_coalescing_cam_unit ecc_checker u_checker (.*);

// ===== tb/event_coalescing_cam_unit_tb.sv =====
// Self-checking bench for the event coalescing store: directed and random stream traffic.
module event_coalescing_cam_unit_tb;

    localparam int DEPTH    = 16;
    localparam int POOL_MAX = 24;

    localparam int MODE_FREE       = 0;
    localparam int MODE_SRC_IDLE   = 1;
    localparam int MODE_SINK_STALL = 2;
    localparam int MODE_BOTH       = 3;

    localparam ecc_pkg::key_t KEY_ONES = '1;
    localparam ecc_pkg::key_t KEY_LSB  = 48'h0000_0000_0001;
    localparam ecc_pkg::key_t KEY_MSB  = 48'h8000_0000_0000;
    localparam ecc_pkg::key_t KEY_NEAR = 48'hFFFF_FFFF_FFFE;
    localparam ecc_pkg::key_t KEY_HALF = 48'h7FFF_FFFF_FFFF;
    localparam ecc_pkg::key_t KEY_A    = 48'h1234_5678_9ABC;
    localparam ecc_pkg::key_t KEY_B    = 48'hA5A5_5A5A_0F0F;
    localparam ecc_pkg::key_t KEY_C    = 48'h0000_FFFF_0000;

    // Tracks the store contents and the found flag owed for each accepted word.
    class coalesce_scoreboard;
        ecc_pkg::key_t              keys_seen[DEPTH];
        int unsigned                ring_ptr;
        logic [ecc_pkg::CFG_W-1:0]  size_reg;
        bit                         found_expected[$];
        int unsigned                errors;
        int unsigned                checks;
        int unsigned                adds;
        int unsigned                hits;
        int unsigned                results;

        function new();
            foreach (keys_seen[i]) keys_seen[i] = '0;
            ring_ptr = 0;
            size_reg = ecc_pkg::CFG_RESET;
            errors   = 0;
            checks   = 0;
            adds     = 0;
            hits     = 0;
            results  = 0;
        endfunction

        // Clamp the size register to 1..DEPTH.
        function int unsigned live_entries();
            int unsigned n;
            n = size_reg;
            if (n == 0) n = 1;
            if (n > DEPTH) n = DEPTH;
            return n;
        endfunction

        function bit probe_key(ecc_pkg::key_t k);
            int unsigned n;
            n = live_entries();
            if (k == '0) return 1'b0;
            for (int unsigned i = 0; i < n; i++)
            begin
                // an empty entry ends the search
                if (keys_seen[i] == '0) return 1'b0;
                if (keys_seen[i] == k) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void record_key(ecc_pkg::key_t k);
            int unsigned n;
            int unsigned p;
            n = live_entries();
            p = ring_ptr;
            if (k == '0) return;
            if (p >= n) p = 0;
            keys_seen[p] = k;
            p++;
            if (p >= n) p = 0;
            ring_ptr = p;
        endfunction

        function void note_word(ecc_pkg::action_t act, ecc_pkg::key_t k);
            bit hit;
            hit = 1'b0;
            if (act == ecc_pkg::ACT_ADD)
            begin
                record_key(k);
                adds++;
            end
            else
            begin
                hit = probe_key(k);
                checks++;
                if (hit) hits++;
            end
            found_expected.push_back(hit);
        endfunction

        function void check_found(logic found);
            bit want;
            if (found_expected.size() == 0)
            begin
                $error("result word with nothing owed: found=%0b", found);
                errors++;
                return;
            end
            want = found_expected.pop_front();
            results++;
            if (found !== want)
            begin
                $error("found mismatch: expected %0b, actual %0b", want, found);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return found_expected.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n          = 1'b0;
    logic                       cfg_wr_en      = 1'b0;
    logic [ecc_pkg::CFG_W-1:0]  cfg_wr_data    = '0;
    logic                       s_axis_tvalid  = 1'b0;
    logic                       s_axis_tready;
    logic [47:0]                s_axis_tdata   = '0;   // flag_word[31:0], event_id[47:32]
    logic [0:0]                 s_axis_tuser   = '0;   // action[0]
    logic                       m_axis_tvalid;
    logic                       m_axis_tready  = 1'b0;
    logic [7:0]                 m_axis_tdata;          // found[0], zero fill[7:1]

    int unsigned        src_idle_pct   = 0;
    int unsigned        sink_stall_pct = 0;
    int unsigned        cfg_writes     = 0;

    coalesce_scoreboard sb;

    event_coalescing_cam_unit #(
        .DEPTH (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("event_coalescing_cam_unit verification failed");
        $finish;
    end

    // Check each delivered word and pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_found(m_axis_tdata[0]);
        m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic set_pacing(int mode);
        src_idle_pct   = (mode == MODE_SRC_IDLE) ? 63 : (mode == MODE_BOTH) ? 27 : 0;
        sink_stall_pct = (mode == MODE_SINK_STALL) ? 63 : (mode == MODE_BOTH) ? 27 : 0;
    endtask

    task automatic push_word(ecc_pkg::action_t act, ecc_pkg::key_t k);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {k[ecc_pkg::ID_W-1:0], k[ecc_pkg::KEY_W-1:ecc_pkg::ID_W]};
        s_axis_tuser  <= act;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_word(act, k);
    endtask

    // Drain all owed results, then write the size register.
    task automatic write_size(logic [ecc_pkg::CFG_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.size_reg = v;
        cfg_writes++;
    endtask

    function automatic ecc_pkg::key_t random_key();
        ecc_pkg::key_t k;
        int unsigned roll;
        k = {$urandom, 16'($urandom)};
        roll = $urandom_range(99);
        if (roll < 10) k[ecc_pkg::KEY_W-1:ecc_pkg::ID_W] = '0;
        else if (roll < 20) k[ecc_pkg::ID_W-1:0] = '0;
        return k;
    endfunction

    // Mostly reuse a small key pool so that adds and checks collide.
    task automatic run_phase(int unsigned n_items);
        ecc_pkg::key_t      pool[POOL_MAX];
        int unsigned        pool_n;
        int unsigned        pick;
        int unsigned        roll;
        ecc_pkg::key_t      k;
        ecc_pkg::action_t   act;
        pool_n = $urandom_range(POOL_MAX, 3);
        for (int i = 0; i < POOL_MAX; i++) pool[i] = random_key();
        repeat (n_items)
        begin
            pick = $urandom_range(pool_n - 1);
            roll = $urandom_range(99);
            if (roll < 75) k = pool[pick];
            else if (roll < 85)
                k = pool[pick] ^ (ecc_pkg::key_t'(1) << $urandom_range(ecc_pkg::KEY_W - 1));
            else if (roll < 95) k = random_key();
            else k = '0;
            act = ($urandom_range(99) < 40) ? ecc_pkg::ACT_ADD : ecc_pkg::ACT_CHECK;
            push_word(act, k);
        end
    endtask

    initial
    begin
        logic [ecc_pkg::CFG_W-1:0] sizes[8];
        sizes = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd2, 5'd16};
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pacing(MODE_FREE);
        push_word(ecc_pkg::ACT_CHECK, '0);
        push_word(ecc_pkg::ACT_CHECK, KEY_ONES);
        push_word(ecc_pkg::ACT_ADD,   KEY_ONES);
        push_word(ecc_pkg::ACT_CHECK, KEY_ONES);
        push_word(ecc_pkg::ACT_ADD,   '0);
        push_word(ecc_pkg::ACT_CHECK, '0);
        push_word(ecc_pkg::ACT_ADD,   KEY_LSB);
        push_word(ecc_pkg::ACT_ADD,   KEY_MSB);
        push_word(ecc_pkg::ACT_CHECK, KEY_LSB);
        push_word(ecc_pkg::ACT_CHECK, KEY_MSB);
        push_word(ecc_pkg::ACT_CHECK, KEY_NEAR);
        push_word(ecc_pkg::ACT_CHECK, KEY_HALF);

        // slot sits past the new size: the next add lands in entry 0
        write_size(5'd2);
        push_word(ecc_pkg::ACT_ADD,   KEY_A);
        push_word(ecc_pkg::ACT_ADD,   KEY_B);
        push_word(ecc_pkg::ACT_ADD,   KEY_C);
        push_word(ecc_pkg::ACT_CHECK, KEY_A);
        push_word(ecc_pkg::ACT_CHECK, KEY_B);
        push_word(ecc_pkg::ACT_CHECK, KEY_C);
        push_word(ecc_pkg::ACT_CHECK, KEY_MSB);

        // store keeps its contents across the write
        write_size(5'd16);
        push_word(ecc_pkg::ACT_CHECK, KEY_MSB);
        push_word(ecc_pkg::ACT_CHECK, KEY_ONES);

        write_size(5'd0);
        push_word(ecc_pkg::ACT_ADD,   KEY_A);
        push_word(ecc_pkg::ACT_ADD,   KEY_B);
        push_word(ecc_pkg::ACT_CHECK, KEY_A);
        push_word(ecc_pkg::ACT_CHECK, KEY_B);

        foreach (sizes[i])
        begin
            write_size(sizes[i]);
            set_pacing(i % 4);
            run_phase(90);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (24) @(posedge clk);

        $display("covered %0d checks (%0d hits) and %0d adds, %0d result words compared",
                 sb.checks, sb.hits, sb.adds, sb.results);
        $display("%0d size writes from 0 to 31 under free, idle, stall and mixed pacing",
                 cfg_writes);
        if (sb.errors == 0)
            $display("event_coalescing_cam_unit verification clean");
        else
            $display("event_coalescing_cam_unit verification failed");
        $finish;
    end

endmodule
